// ===== hdl/svpwm_sector_timing_assert.svh =====
// Assertion macros for the space vector PWM sector and timing block.
// Self-contained; users must provide clk_i and rst_ni in scope.
`ifndef SVPWM_SECTOR_TIMING_ASSERT_SVH
`define SVPWM_SECTOR_TIMING_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define SVPWM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define SVPWM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SVPWM_ASSERT_IMP(lbl, ante, cons, msg)
`define SVPWM_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ===== hdl/svpwm_pkg.sv =====
// Shared types and constants for the space vector PWM sector and timing block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package svpwm_pkg;

  localparam int VOLT_BITS_DEF   = 16;
  localparam int TIME_BITS_DEF   = 16;
  localparam int PERIOD_REG_BITS = 16;
  localparam int GAIN_BITS       = 24;
  localparam int CFG_DATA_BITS   = 24;
  localparam int CFG_IDX_BITS    = 1;
  localparam int PERIOD_RESET    = 25600;
  localparam int GAIN_RESET      = 405400;
  localparam int HALF_SQRT3_Q16  = 56756;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_PERIOD,
    REG_GAIN
  } reg_idx_e;

  typedef enum logic [2:0] {
    SECTOR_ZERO,
    SECTOR_1,
    SECTOR_2,
    SECTOR_3,
    SECTOR_4,
    SECTOR_5,
    SECTOR_6
  } sector_e;

  // Sign code: bit 0 for v1 > 0, bit 1 for v2 > 0, bit 2 for v3 > 0.
  localparam logic [2:0] CODE_S1   = 3'b011;
  localparam logic [2:0] CODE_S2   = 3'b001;
  localparam logic [2:0] CODE_S3   = 3'b101;
  localparam logic [2:0] CODE_S4   = 3'b100;
  localparam logic [2:0] CODE_S5   = 3'b110;
  localparam logic [2:0] CODE_S6   = 3'b010;
  localparam logic [2:0] CODE_NONE = 3'b000;
  localparam logic [2:0] CODE_ALL  = 3'b111;

  typedef struct packed {
    logic       valid;
    logic [2:0] code;
  } ctl_t;

endpackage

`default_nettype wire

// ===== hdl/svpwm_proj.sv =====
// Projection stages: input register, sqrt3/2 product, projections, sign code
// and rounding to Q.10 volts. Depends on svpwm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module svpwm_proj #(
  parameter int VOLT_BITS = svpwm_pkg::VOLT_BITS_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start_i,
  input  wire logic signed [VOLT_BITS-1:0]    volt_alpha_i,
  input  wire logic signed [VOLT_BITS-1:0]    volt_beta_i,
  output svpwm_pkg::ctl_t                     ctl_o,
  output logic signed [VOLT_BITS+1:0]         r1_o,
  output logic signed [VOLT_BITS+1:0]         r2_o,
  output logic signed [VOLT_BITS+1:0]         r3_o
);

  localparam int PW = VOLT_BITS + 17;
  localparam int RW = VOLT_BITS + 2;
  localparam logic signed [PW-1:0] K_HS = PW'(svpwm_pkg::HALF_SQRT3_Q16);
  localparam logic [PW-1:0] RND_Q26 = PW'(32768);

  logic                        v1_q, v2_q, v3_q, v4_q;
  logic signed [VOLT_BITS-1:0] a1_q, b1_q, b2_q, b3_q;
  logic signed [PW-1:0]        pa2_q, p2_3_q, p3_3_q;
  logic signed [PW-1:0]        a_ext, b_ext, pa_d, p2_d, p3_d;
  logic [2:0]                  code4_q, code_d;
  logic signed [RW-1:0]        r1_q, r2_q, r3_q, r2_d, r3_d;

  function automatic logic signed [RW-1:0] round_q10(input logic signed [PW-1:0] p);
    logic          neg;
    logic [PW-1:0] mag;
    logic [PW-1:0] sum;
    logic [RW-1:0] m;
    neg = p[PW-1];
    mag = neg ? PW'(-p) : PW'(p);
    sum = mag + RND_Q26;
    m   = {1'b0, sum[PW-1:16]};
    return neg ? $signed(-m) : $signed(m);
  endfunction

  assign a_ext = PW'(a1_q);
  assign b_ext = PW'(b2_q);
  assign pa_d  = a_ext * K_HS;
  assign p2_d  = pa2_q - (b_ext <<< 15);
  assign p3_d  = -pa2_q - (b_ext <<< 15);

  assign code_d[0] = !b3_q[VOLT_BITS-1] && (b3_q != '0);
  assign code_d[1] = !p2_3_q[PW-1] && (p2_3_q != '0);
  assign code_d[2] = !p3_3_q[PW-1] && (p3_3_q != '0);
  assign r2_d      = round_q10(p2_3_q);
  assign r3_d      = round_q10(p3_3_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= start_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    a1_q    <= volt_alpha_i;
    b1_q    <= volt_beta_i;
    pa2_q   <= pa_d;
    b2_q    <= b1_q;
    p2_3_q  <= p2_d;
    p3_3_q  <= p3_d;
    b3_q    <= b2_q;
    code4_q <= code_d;
    r1_q    <= RW'(b3_q);
    r2_q    <= r2_d;
    r3_q    <= r3_d;
  end

  assign ctl_o.valid = v4_q;
  assign ctl_o.code  = code4_q;
  assign r1_o        = r1_q;
  assign r2_o        = r2_q;
  assign r3_o        = r3_q;

endmodule

`default_nettype wire

// ===== hdl/svpwm_scale.sv =====
// Gain stage: multiplies the three projections, two of them rounded, by the gain register.
// Depends on svpwm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module svpwm_scale #(
  parameter int VOLT_BITS = svpwm_pkg::VOLT_BITS_DEF
) (
  input  wire logic                                        clk_i,
  input  wire logic                                        rst_ni,
  input  wire svpwm_pkg::ctl_t                             ctl_i,
  input  wire logic signed [VOLT_BITS+1:0]                 r1_i,
  input  wire logic signed [VOLT_BITS+1:0]                 r2_i,
  input  wire logic signed [VOLT_BITS+1:0]                 r3_i,
  input  wire logic [svpwm_pkg::GAIN_BITS-1:0]             gain_i,
  output svpwm_pkg::ctl_t                                  ctl_o,
  output logic signed [VOLT_BITS+svpwm_pkg::GAIN_BITS+1:0] k1_o,
  output logic signed [VOLT_BITS+svpwm_pkg::GAIN_BITS+1:0] k2_o,
  output logic signed [VOLT_BITS+svpwm_pkg::GAIN_BITS+1:0] k3_o
);

  localparam int KW = VOLT_BITS + svpwm_pkg::GAIN_BITS + 2;

  logic                 v_q;
  logic [2:0]           code_q;
  logic signed [KW-1:0] g_ext, k1_q, k2_q, k3_q;
  logic signed [KW-1:0] r1_ext, r2_ext, r3_ext;

  assign g_ext  = $signed(KW'(gain_i));
  assign r1_ext = KW'(r1_i);
  assign r2_ext = KW'(r2_i);
  assign r3_ext = KW'(r3_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else begin
      v_q <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    code_q <= ctl_i.code;
    k1_q   <= g_ext * r1_ext;
    k2_q   <= g_ext * r2_ext;
    k3_q   <= g_ext * r3_ext;
  end

  assign ctl_o.valid = v_q;
  assign ctl_o.code  = code_q;
  assign k1_o        = k1_q;
  assign k2_o        = k2_q;
  assign k3_o        = k3_q;

endmodule

`default_nettype wire

// ===== hdl/svpwm_phase.sv =====
// Phase stages: sector decode, centered phase times, rounding, clamping and
// the output register. Depends on svpwm_pkg and the assertion macros.
`timescale 1ns / 1ps
`default_nettype none
`include "svpwm_sector_timing_assert.svh"

module svpwm_phase #(
  parameter int VOLT_BITS = svpwm_pkg::VOLT_BITS_DEF,
  parameter int TIME_BITS = svpwm_pkg::TIME_BITS_DEF
) (
  input  wire logic                                        clk_i,
  input  wire logic                                        rst_ni,
  input  wire svpwm_pkg::ctl_t                             ctl_i,
  input  wire logic signed [VOLT_BITS+svpwm_pkg::GAIN_BITS+1:0] k1_i,
  input  wire logic signed [VOLT_BITS+svpwm_pkg::GAIN_BITS+1:0] k2_i,
  input  wire logic signed [VOLT_BITS+svpwm_pkg::GAIN_BITS+1:0] k3_i,
  input  wire logic [((TIME_BITS < svpwm_pkg::PERIOD_REG_BITS) ? TIME_BITS :
                      svpwm_pkg::PERIOD_REG_BITS)-1:0]     period_i,
  output logic                                             done_o,
  output logic [2:0]                                       sector_o,
  output logic [TIME_BITS-1:0]                             time_a_o,
  output logic [TIME_BITS-1:0]                             time_b_o,
  output logic [TIME_BITS-1:0]                             time_c_o
);

  localparam int PER_BITS = (TIME_BITS < svpwm_pkg::PERIOD_REG_BITS) ?
                            TIME_BITS : svpwm_pkg::PERIOD_REG_BITS;
  localparam int KW = VOLT_BITS + svpwm_pkg::GAIN_BITS + 2;
  localparam int TW = KW + 1;
  localparam logic [TW-1:0] RND_HALF = TW'(1) << 18;

  logic signed [TW-1:0] per, k1, k2, k3;
  logic signed [TW-1:0] ta_d, tb_d, tc_d, ta6_q, tb6_q, tc6_q;
  svpwm_pkg::sector_e   sec_d, sec6_q, sector_q;
  logic                 v6_q, done_q;
  logic [TIME_BITS-1:0] half, per_t;
  logic [TIME_BITS-1:0] time_a_d, time_b_d, time_c_d;
  logic [TIME_BITS-1:0] time_a_q, time_b_q, time_c_q;

  function automatic logic [TIME_BITS-1:0] finish_time(input logic signed [TW-1:0] t,
                                                       input logic [PER_BITS-1:0] p);
    logic [TW-1:0] u;
    logic [TW-1:0] pe;
    u  = ($unsigned(t) + RND_HALF) >> 19;
    pe = TW'(p);
    if (t[TW-1] || (t == '0)) begin
      return '0;
    end else if (u > pe) begin
      return TIME_BITS'(p);
    end
    return TIME_BITS'(u);
  endfunction

  assign per = $signed(TW'({period_i, 18'd0}));
  assign k1  = TW'(k1_i);
  assign k2  = TW'(k2_i);
  assign k3  = TW'(k3_i);

  always_comb begin
    ta_d  = '0;
    tb_d  = '0;
    tc_d  = '0;
    sec_d = svpwm_pkg::SECTOR_ZERO;
    case (ctl_i.code)
      svpwm_pkg::CODE_S1: begin
        sec_d = svpwm_pkg::SECTOR_1;
        ta_d  = per - k1 - k2;
        tb_d  = per - k1 + k2;
        tc_d  = per + k1 + k2;
      end
      svpwm_pkg::CODE_S2: begin
        sec_d = svpwm_pkg::SECTOR_2;
        ta_d  = per - k2 + k3;
        tb_d  = per + k2 + k3;
        tc_d  = per - k2 - k3;
      end
      svpwm_pkg::CODE_S3: begin
        sec_d = svpwm_pkg::SECTOR_3;
        ta_d  = per + k1 + k3;
        tb_d  = per - k1 - k3;
        tc_d  = per + k1 - k3;
      end
      svpwm_pkg::CODE_S4: begin
        sec_d = svpwm_pkg::SECTOR_4;
        ta_d  = per - k1 - k2;
        tb_d  = per - k1 + k2;
        tc_d  = per + k1 + k2;
      end
      svpwm_pkg::CODE_S5: begin
        sec_d = svpwm_pkg::SECTOR_5;
        ta_d  = per + k3 - k2;
        tb_d  = per + k3 + k2;
        tc_d  = per - k3 - k2;
      end
      svpwm_pkg::CODE_S6: begin
        sec_d = svpwm_pkg::SECTOR_6;
        ta_d  = per + k3 + k1;
        tb_d  = per - k3 - k1;
        tc_d  = per - k3 + k1;
      end
      default: begin
        sec_d = svpwm_pkg::SECTOR_ZERO;
      end
    endcase
  end

  assign half  = TIME_BITS'(period_i >> 1);
  assign per_t = TIME_BITS'(period_i);

  always_comb begin
    if (sec6_q == svpwm_pkg::SECTOR_ZERO) begin
      time_a_d = half;
      time_b_d = half;
      time_c_d = half;
    end else begin
      time_a_d = finish_time(ta6_q, period_i);
      time_b_d = finish_time(tb6_q, period_i);
      time_c_d = finish_time(tc6_q, period_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v6_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      v6_q   <= ctl_i.valid;
      done_q <= v6_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sec6_q   <= sec_d;
    ta6_q    <= ta_d;
    tb6_q    <= tb_d;
    tc6_q    <= tc_d;
    sector_q <= sec6_q;
    time_a_q <= time_a_d;
    time_b_q <= time_b_d;
    time_c_q <= time_c_d;
  end

  assign done_o   = done_q;
  assign sector_o = sector_q;
  assign time_a_o = time_a_q;
  assign time_b_o = time_b_q;
  assign time_c_o = time_c_q;

  `SVPWM_ASSERT_IMP(a_zero_half, done_q && (sector_q == svpwm_pkg::SECTOR_ZERO),
    (time_a_q == half) && (time_b_q == half) && (time_c_q == half),
    "zero vector times are not half the period")
  `SVPWM_ASSERT_IMP(a_clamp, done_q,
    (time_a_q <= per_t) && (time_b_q <= per_t) && (time_c_q <= per_t),
    "phase time exceeds the period")
  `SVPWM_ASSERT_NXT(a_zero_code,
    ctl_i.valid && ((ctl_i.code == svpwm_pkg::CODE_NONE) ||
                    (ctl_i.code == svpwm_pkg::CODE_ALL)),
    v6_q && (sec6_q == svpwm_pkg::SECTOR_ZERO),
    "null sign code did not decode to the zero sector")

endmodule

`default_nettype wire

// ===== hdl/svpwm_sector_timing.sv =====
// Seven-segment space vector PWM sector and phase timing, top level.
// A result is strobed on done_o once its request has passed the projection, gain and phase stage registers.
// Throughput: one request per clock; busy_o stays low and the pipeline never stalls.
// Results cannot be held off by the receiver; each is shown for one cycle.
// Reset clears the pipeline valid bits and loads the default period and gain.
`timescale 1ns / 1ps
`default_nettype none
`include "svpwm_sector_timing_assert.svh"

module svpwm_sector_timing #(
  parameter int VOLT_BITS = svpwm_pkg::VOLT_BITS_DEF,
  parameter int TIME_BITS = svpwm_pkg::TIME_BITS_DEF
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  start_i,
  output logic                                       busy_o,
  input  wire logic signed [VOLT_BITS-1:0]           volt_alpha_i,
  input  wire logic signed [VOLT_BITS-1:0]           volt_beta_i,
  input  wire logic                                  cfg_we_i,
  input  wire logic [svpwm_pkg::CFG_IDX_BITS-1:0]    cfg_index_i,
  input  wire logic [svpwm_pkg::CFG_DATA_BITS-1:0]   cfg_wdata_i,
  output logic                                       done_o,
  output logic [2:0]                                 sector_o,
  output logic [TIME_BITS-1:0]                       time_a_o,
  output logic [TIME_BITS-1:0]                       time_b_o,
  output logic [TIME_BITS-1:0]                       time_c_o
);

  localparam int PER_BITS = (TIME_BITS < svpwm_pkg::PERIOD_REG_BITS) ?
                            TIME_BITS : svpwm_pkg::PERIOD_REG_BITS;
  localparam int RW = VOLT_BITS + 2;
  localparam int KW = VOLT_BITS + svpwm_pkg::GAIN_BITS + 2;
  localparam logic [PER_BITS-1:0] PERIOD_RST = PER_BITS'(svpwm_pkg::PERIOD_RESET);
  localparam logic [svpwm_pkg::GAIN_BITS-1:0] GAIN_RST =
    svpwm_pkg::GAIN_BITS'(svpwm_pkg::GAIN_RESET);

  logic [PER_BITS-1:0]            period_q, period_d;
  logic [svpwm_pkg::GAIN_BITS-1:0] gain_q, gain_d;
  svpwm_pkg::ctl_t                proj_ctl, scale_ctl;
  logic signed [RW-1:0]           r1, r2, r3;
  logic signed [KW-1:0]           k1, k2, k3;
  logic                           accept;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  always_comb begin
    period_d = period_q;
    gain_d   = gain_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        svpwm_pkg::REG_PERIOD: period_d = cfg_wdata_i[PER_BITS-1:0];
        svpwm_pkg::REG_GAIN:   gain_d   = cfg_wdata_i[svpwm_pkg::GAIN_BITS-1:0];
        default: begin
          period_d = period_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= PERIOD_RST;
      gain_q   <= GAIN_RST;
    end else begin
      period_q <= period_d;
      gain_q   <= gain_d;
    end
  end

  svpwm_proj #(
    .VOLT_BITS(VOLT_BITS)
  ) u_proj (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (accept),
    .volt_alpha_i(volt_alpha_i),
    .volt_beta_i (volt_beta_i),
    .ctl_o       (proj_ctl),
    .r1_o        (r1),
    .r2_o        (r2),
    .r3_o        (r3)
  );

  svpwm_scale #(
    .VOLT_BITS(VOLT_BITS)
  ) u_scale (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctl_i (proj_ctl),
    .r1_i  (r1),
    .r2_i  (r2),
    .r3_i  (r3),
    .gain_i(gain_q),
    .ctl_o (scale_ctl),
    .k1_o  (k1),
    .k2_o  (k2),
    .k3_o  (k3)
  );

  svpwm_phase #(
    .VOLT_BITS(VOLT_BITS),
    .TIME_BITS(TIME_BITS)
  ) u_phase (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (scale_ctl),
    .k1_i    (k1),
    .k2_i    (k2),
    .k3_i    (k3),
    .period_i(period_q),
    .done_o  (done_o),
    .sector_o(sector_o),
    .time_a_o(time_a_o),
    .time_b_o(time_b_o),
    .time_c_o(time_c_o)
  );

  `SVPWM_ASSERT_IMP(a_latency, done_o, $past(accept, 7), "result strobe without a request")

endmodule

`default_nettype wire
